// ----- hw/rtl/gcdn_pkg.sv -----
// ----------------------------------------------------------------------------
// gcdn_pkg
// Shared types and constants for the GC-adjusted depth normalizer.
// ----------------------------------------------------------------------------
package gcdn_pkg;

  localparam int POS_W       = 28;
  localparam int GC_W        = 7;
  localparam int DEPTH_W     = 7;
  localparam int RAW_W       = 16;
  localparam int DRAW_W      = 16;
  localparam int CHROM_W     = 8;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 40;
  localparam int OUT_DEPTH_W = 23;
  localparam int REL_W       = 24;
  localparam int MIN_DIST_W  = 16;
  localparam int CFG_DATA_W  = 28;
  localparam int CFG_IDX_W   = 2;
  // Widest histogram address: three types of up to 1024 bins
  localparam int ADDR_W      = 12;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;

  localparam logic [OUT_DEPTH_W-1:0] DEPTH_MAX = 23'h7FFFFF;
  localparam logic [REL_W-1:0]       REL_MAX   = 24'hFFFFFF;

  localparam logic [1:0] CT_AUTO  = 2'd0;
  localparam logic [1:0] CT_X     = 2'd1;
  localparam logic [1:0] CT_Y     = 2'd2;
  localparam logic [1:0] CT_OTHER = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_START   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STOP    = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REM,
    OP_FIN
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [ADDR_W-1:0]    addr;
    logic [DEPTH_W-1:0]   depth;
    logic [CNT_W-1:0]     cnt_a;
    logic [CNT_W-1:0]     cnt_x;
    logic [CNT_W-1:0]     cnt_y;
  } qentry_t;

  typedef struct packed {
    logic [MIN_DIST_W-1:0] min_distance;
    logic [DEPTH_W-1:0]    depth_cap;
    logic [POS_W-1:0]      x_start;
    logic [POS_W-1:0]      x_stop;
  } cfg_t;

  typedef enum logic [4:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_OP_RD,
    BK_OP_WB,
    BK_AS_RD,
    BK_AS_ACC,
    BK_AD_START,
    BK_AD_WAIT,
    BK_TB_RD,
    BK_TB_CHK,
    BK_TB_WAIT,
    BK_TA_RD,
    BK_TA_MUL,
    BK_TA_ACC,
    BK_T_NEXT,
    BK_TF_START,
    BK_TF_WAIT,
    BK_RX_START,
    BK_RX_WAIT,
    BK_RY_START,
    BK_RY_WAIT,
    BK_OUT
  } back_state_t;

endpackage

// ----- hw/rtl/gcdn_queue.sv -----
// ----------------------------------------------------------------------------
// gcdn_queue
// Small FIFO of histogram operations between front and back.
// ----------------------------------------------------------------------------
module gcdn_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gcdn_pkg::qentry_t push_data,
  output logic              full,
  input  logic              pop,
  output gcdn_pkg::qentry_t pop_data,
  output logic              empty
);
  import gcdn_pkg::*;

  qentry_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_r, rptr_r;
  logic [Q_PTR_W:0]     count_r;

  assign full     = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_data;
  end

endmodule

// ----- hw/rtl/gcdn_front.sv -----
// ----------------------------------------------------------------------------
// gcdn_front
// Takes input words, tracks chromosome and cluster state, issues bin ops.
// ----------------------------------------------------------------------------
module gcdn_front #(
  parameter int GC_BINS           = 128,
  parameter int CLUSTER_SIZE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gcdn_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [gcdn_pkg::CHROM_W-1:0]  in_chrom_id,
  input  logic [1:0]                    in_chrom_type,
  input  logic [gcdn_pkg::POS_W-1:0]    in_position,
  input  logic [gcdn_pkg::GC_W-1:0]     in_gc_bin,
  input  logic                          in_gc_unknown,
  input  logic [gcdn_pkg::RAW_W-1:0]    in_raw_depth,
  input  logic [gcdn_pkg::DRAW_W-1:0]   in_random_draw,
  input  logic                          clear_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output gcdn_pkg::qentry_t             q_data
);
  import gcdn_pkg::*;

  localparam int CSB = CLUSTER_SIZE_BITS;
  localparam int PW  = DRAW_W + 1 + CSB;
  localparam logic [CSB-1:0]    SIZE_MAX = {CSB{1'b1}};
  localparam logic [ADDR_W-1:0] BASE_X   = ADDR_W'(GC_BINS);
  localparam logic [ADDR_W-1:0] BASE_Y   = ADDR_W'(2 * GC_BINS);

  logic                have_r, open_r, held_known_r, pend_r;
  logic [CHROM_W-1:0]  cur_r;
  logic [POS_W-1:0]    end_r;
  logic [CSB-1:0]      size_r;
  logic [GC_W-1:0]     held_gc_r;
  logic [DEPTH_W-1:0]  held_depth_r;
  logic [CNT_W-1:0]    cnt_a_r, cnt_x_r, cnt_y_r;
  qentry_t             pend_data_r;

  logic                accept, is_rec, chg, win_out, gc_known, new_cl, replace;
  logic                open_e, held_known_e;
  logic [CSB-1:0]      size_e, size_inc;
  logic [GC_W-1:0]     held_gc_e;
  logic [DEPTH_W-1:0]  held_depth_e, depth;
  logic [POS_W-1:0]    gap;
  logic [PW-1:0]       prod;
  logic [ADDR_W-1:0]   base;
  logic                do_rem, do_add, act;
  qentry_t             add_ent, rem_ent, fin_ent;

  assign in_ready = !pend_r && !q_full && !clear_busy;
  assign accept   = in_valid && in_ready;
  assign is_rec   = accept && !in_command && (in_chrom_type != CT_OTHER);

  // Chromosome change drops the open cluster before anything else
  assign chg          = !have_r || (in_chrom_id != cur_r);
  assign open_e       = chg ? 1'b0 : open_r;
  assign size_e       = chg ? '0 : size_r;
  assign held_known_e = chg ? 1'b0 : held_known_r;
  assign held_gc_e    = chg ? '0 : held_gc_r;
  assign held_depth_e = chg ? '0 : held_depth_r;

  assign win_out  = (in_chrom_type == CT_X) &&
                    ((in_position < cfg.x_start) || (in_position >= cfg.x_stop));
  assign gc_known = !in_gc_unknown && (32'(in_gc_bin) < GC_BINS);
  assign depth    = (in_raw_depth > RAW_W'(cfg.depth_cap)) ? cfg.depth_cap
                                                           : in_raw_depth[DEPTH_W-1:0];

  assign gap      = in_position - end_r;
  assign new_cl   = !open_e || ((in_position >= end_r) &&
                                (gap >= POS_W'(cfg.min_distance)));
  assign size_inc = (size_e == SIZE_MAX) ? size_e : size_e + 1'b1;
  assign prod     = PW'({in_random_draw, 1'b1}) * PW'(size_inc);
  assign replace  = (prod < PW'(131072));

  assign act    = is_rec && !win_out;
  assign do_add = gc_known && (new_cl || replace);
  assign do_rem = !new_cl && replace && held_known_e;

  always_comb begin
    unique case (in_chrom_type)
      CT_X:    base = BASE_X;
      CT_Y:    base = BASE_Y;
      default: base = '0;
    endcase
  end

  always_comb begin
    add_ent       = '0;
    add_ent.kind  = OP_ADD;
    add_ent.addr  = base + ADDR_W'(in_gc_bin);
    add_ent.depth = depth;
    rem_ent       = '0;
    rem_ent.kind  = OP_REM;
    rem_ent.addr  = base + ADDR_W'(held_gc_e);
    rem_ent.depth = held_depth_e;
    fin_ent       = '0;
    fin_ent.kind  = OP_FIN;
    fin_ent.cnt_a = cnt_a_r;
    fin_ent.cnt_x = cnt_x_r;
    fin_ent.cnt_y = cnt_y_r;
  end

  always_comb begin
    q_push = 1'b0;
    q_data = add_ent;
    if (pend_r) begin
      q_push = !q_full;
      q_data = pend_data_r;
    end else if (accept && in_command) begin
      q_push = 1'b1;
      q_data = fin_ent;
    end else if (act && do_rem) begin
      q_push = 1'b1;
      q_data = rem_ent;
    end else if (act && do_add) begin
      q_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r       <= 1'b0;
      cur_r        <= '0;
      open_r       <= 1'b0;
      end_r        <= '0;
      size_r       <= '0;
      held_known_r <= 1'b0;
      held_gc_r    <= '0;
      held_depth_r <= '0;
      cnt_a_r      <= '0;
      cnt_x_r      <= '0;
      cnt_y_r      <= '0;
      pend_r       <= 1'b0;
    end else begin
      if (pend_r && !q_full) pend_r <= 1'b0;
      if (is_rec) begin
        have_r <= 1'b1;
        cur_r  <= in_chrom_id;
        if (win_out) begin
          open_r       <= open_e;
          end_r        <= chg ? '0 : end_r;
          size_r       <= size_e;
          held_known_r <= held_known_e;
          held_gc_r    <= held_gc_e;
          held_depth_r <= held_depth_e;
        end else begin
          open_r <= 1'b1;
          end_r  <= in_position;
          size_r <= new_cl ? CSB'(1) : size_inc;
          if (new_cl || replace) begin
            held_known_r <= gc_known;
            held_gc_r    <= in_gc_bin;
            held_depth_r <= depth;
          end else begin
            held_known_r <= held_known_e;
            held_gc_r    <= held_gc_e;
            held_depth_r <= held_depth_e;
          end
          if (new_cl) begin
            case (in_chrom_type)
              CT_AUTO: if (cnt_a_r != '1) cnt_a_r <= cnt_a_r + 1'b1;
              CT_X:    if (cnt_x_r != '1) cnt_x_r <= cnt_x_r + 1'b1;
              default: if (cnt_y_r != '1) cnt_y_r <= cnt_y_r + 1'b1;
            endcase
          end
          // remove goes first, the add waits in the pending register until pushed
          if (do_rem && do_add) pend_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act && do_rem && do_add) pend_data_r <= add_ent;
  end

endmodule

// ----- hw/rtl/gcdn_divider.sv -----
// ----------------------------------------------------------------------------
// gcdn_divider
// Restoring divider, one quotient bit per cycle, rounds half up.
// ----------------------------------------------------------------------------
module gcdn_divider #(
  parameter int NUM_W = 63,
  parameter int DEN_W = 39
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W:0]   quot
);
  localparam int NQ = NUM_W + 1;
  localparam int CW = $clog2(NQ + 1);

  logic             busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [NQ-1:0]    sh_r;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_r, sh_r[NQ-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quot  = sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NQ);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= NQ'(num) + NQ'(den >> 1);
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_r  <= {sh_r[NQ-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/gcdn_back.sv -----
// ----------------------------------------------------------------------------
// gcdn_back
// Histogram memory, bin read-modify-write, finish sequencer, result register.
// ----------------------------------------------------------------------------
module gcdn_back #(
  parameter int GC_BINS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  gcdn_pkg::qentry_t                 q_data,
  output logic                              q_pop,
  output logic                              clear_busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcdn_pkg::OUT_DEPTH_W-1:0]  out_autosome_depth,
  output logic [gcdn_pkg::OUT_DEPTH_W-1:0]  out_x_depth,
  output logic [gcdn_pkg::OUT_DEPTH_W-1:0]  out_y_depth,
  output logic [gcdn_pkg::REL_W-1:0]        out_x_relative,
  output logic [gcdn_pkg::REL_W-1:0]        out_y_relative,
  output logic [gcdn_pkg::CNT_W-1:0]        out_autosome_count,
  output logic [gcdn_pkg::CNT_W-1:0]        out_x_count,
  output logic [gcdn_pkg::CNT_W-1:0]        out_y_count
);
  import gcdn_pkg::*;

  localparam int ENTRIES = 3 * GC_BINS;
  localparam int AW      = $clog2(ENTRIES);
  localparam int BW      = $clog2(GC_BINS);
  localparam int MW      = CNT_W + SUM_W;
  localparam int TOT_W   = CNT_W + BW;
  localparam int DP_W    = SUM_W + BW;
  localparam int PROD_W  = OUT_DEPTH_W + CNT_W;
  localparam int ACC_W   = PROD_W + BW;
  localparam int NUM_W   = DP_W + 16;
  localparam logic [BW-1:0]     G_LAST   = BW'(GC_BINS - 1);
  localparam logic [AW-1:0]     CLR_LAST = AW'(ENTRIES - 1);
  localparam logic [ADDR_W-1:0] BASE_X   = ADDR_W'(GC_BINS);
  localparam logic [ADDR_W-1:0] BASE_Y   = ADDR_W'(2 * GC_BINS);

  logic [MW-1:0]  mem [ENTRIES];
  logic [MW-1:0]  rdata_r;
  logic [ADDR_W-1:0] raddr, waddr;
  logic           we;
  logic [MW-1:0]  wdata;

  back_state_t    state_r, state_nxt;
  qentry_t        ent_r;
  logic [AW-1:0]  clr_r;
  logic [BW-1:0]  g_r;
  logic           t_y_r;
  logic [TOT_W-1:0] atot_r;
  logic [DP_W-1:0]  adp_r;
  logic [ACC_W-1:0] acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [OUT_DEPTH_W-1:0] adepth_r, m_r, xd_r, yd_r;
  logic [REL_W-1:0] xr_r, yr_r;
  logic           out_valid_r;
  logic           g_last, out_load;

  logic [CNT_W-1:0]  r_cnt, n_cnt;
  logic [SUM_W-1:0]  r_sum, n_sum;
  logic [SUM_W:0]    sum_add;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [TOT_W-1:0] div_den;
  logic [NUM_W:0]   div_q;
  logic [OUT_DEPTH_W-1:0] q_depth;
  logic [REL_W-1:0]       q_rel;

  gcdn_divider #(.NUM_W(NUM_W), .DEN_W(TOT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign r_cnt   = rdata_r[SUM_W +: CNT_W];
  assign r_sum   = rdata_r[SUM_W-1:0];
  assign sum_add = {1'b0, r_sum} + (SUM_W+1)'(ent_r.depth);
  assign g_last  = (g_r == G_LAST);
  assign q_depth = (div_q > (NUM_W+1)'(DEPTH_MAX)) ? DEPTH_MAX : div_q[OUT_DEPTH_W-1:0];
  assign q_rel   = (div_q > (NUM_W+1)'(REL_MAX)) ? REL_MAX : div_q[REL_W-1:0];
  assign out_load = (state_r == BK_OUT) && (!out_valid_r || out_ready);
  assign clear_busy = (state_r == BK_CLEAR);

  // bin update for add and remove words
  always_comb begin
    if (ent_r.kind == OP_REM) begin
      n_cnt = (r_cnt == '0) ? '0 : r_cnt - 1'b1;
      n_sum = (r_sum >= SUM_W'(ent_r.depth)) ? r_sum - SUM_W'(ent_r.depth) : '0;
    end else begin
      n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
      n_sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr[AW-1:0]];
    if (we) mem[waddr[AW-1:0]] <= wdata;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR:    if (clr_r == CLR_LAST) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (!q_empty) state_nxt = (q_data.kind == OP_FIN) ? BK_AS_RD : BK_OP_RD;
      end
      BK_OP_RD:    state_nxt = BK_OP_WB;
      BK_OP_WB:    state_nxt = BK_IDLE;
      BK_AS_RD:    state_nxt = BK_AS_ACC;
      BK_AS_ACC:   state_nxt = g_last ? BK_AD_START : BK_AS_RD;
      BK_AD_START: state_nxt = (atot_r == '0) ? BK_RX_START : BK_AD_WAIT;
      BK_AD_WAIT:  if (div_done) state_nxt = BK_TB_RD;
      BK_TB_RD:    state_nxt = BK_TB_CHK;
      BK_TB_CHK:   state_nxt = (r_cnt == '0) ? BK_T_NEXT : BK_TB_WAIT;
      BK_TB_WAIT:  if (div_done) state_nxt = BK_TA_RD;
      BK_TA_RD:    state_nxt = BK_TA_MUL;
      BK_TA_MUL:   state_nxt = BK_TA_ACC;
      BK_TA_ACC:   state_nxt = BK_T_NEXT;
      BK_T_NEXT:   state_nxt = g_last ? BK_TF_START : BK_TB_RD;
      BK_TF_START: state_nxt = BK_TF_WAIT;
      BK_TF_WAIT:  if (div_done) state_nxt = t_y_r ? BK_RX_START : BK_TB_RD;
      BK_RX_START: state_nxt = (adepth_r == '0) ? BK_OUT : BK_RX_WAIT;
      BK_RX_WAIT:  if (div_done) state_nxt = BK_RY_START;
      BK_RY_START: state_nxt = BK_RY_WAIT;
      BK_RY_WAIT:  if (div_done) state_nxt = BK_OUT;
      BK_OUT:      if (out_load) state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // memory, queue and divider controls
  always_comb begin
    raddr     = ent_r.addr;
    waddr     = ent_r.addr;
    we        = 1'b0;
    wdata     = {n_cnt, n_sum};
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = {adp_r, 16'b0};
    div_den   = atot_r;
    unique case (state_r)
      BK_CLEAR: begin
        we    = 1'b1;
        waddr = ADDR_W'(clr_r);
        wdata = '0;
      end
      BK_IDLE:     q_pop = !q_empty;
      BK_OP_WB:    we = 1'b1;
      BK_AS_RD:    raddr = ADDR_W'(g_r);
      BK_TA_RD:    raddr = ADDR_W'(g_r);
      BK_TB_RD:    raddr = (t_y_r ? BASE_Y : BASE_X) + ADDR_W'(g_r);
      BK_AD_START: div_start = (atot_r != '0);
      BK_TB_CHK: begin
        div_start = (r_cnt != '0);
        div_num   = NUM_W'({r_sum, 16'b0});
        div_den   = TOT_W'(r_cnt);
      end
      BK_TF_START: begin
        div_start = 1'b1;
        div_num   = NUM_W'(acc_r);
      end
      BK_RX_START: begin
        div_start = (adepth_r != '0);
        div_num   = NUM_W'({xd_r, 16'b0});
        div_den   = TOT_W'(adepth_r);
      end
      BK_RY_START: begin
        div_start = 1'b1;
        div_num   = NUM_W'({yd_r, 16'b0});
        div_den   = TOT_W'(adepth_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load)                      out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) ent_r <= q_data;
        g_r    <= '0;
        t_y_r  <= 1'b0;
        atot_r <= '0;
        adp_r  <= '0;
        acc_r  <= '0;
      end
      BK_AS_ACC: begin
        atot_r <= atot_r + TOT_W'(r_cnt);
        adp_r  <= adp_r + DP_W'(r_sum);
        g_r    <= g_last ? '0 : g_r + 1'b1;
      end
      BK_AD_START: begin
        if (atot_r == '0) begin
          adepth_r <= '0;
          xd_r     <= '0;
          yd_r     <= '0;
        end
      end
      BK_AD_WAIT:  if (div_done) adepth_r <= q_depth;
      BK_TB_WAIT:  if (div_done) m_r <= q_depth;
      BK_TA_MUL:   prod_r <= PROD_W'(m_r) * PROD_W'(r_cnt);
      BK_TA_ACC:   acc_r <= acc_r + ACC_W'(prod_r);
      BK_T_NEXT:   g_r <= g_last ? '0 : g_r + 1'b1;
      BK_TF_WAIT: begin
        if (div_done) begin
          if (t_y_r) yd_r <= q_depth;
          else       xd_r <= q_depth;
          t_y_r <= 1'b1;
          acc_r <= '0;
        end
      end
      BK_RX_START: begin
        if (adepth_r == '0) begin
          xr_r <= '0;
          yr_r <= '0;
        end
      end
      BK_RX_WAIT:  if (div_done) xr_r <= q_rel;
      BK_RY_WAIT:  if (div_done) yr_r <= q_rel;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_autosome_depth <= adepth_r;
      out_x_depth        <= xd_r;
      out_y_depth        <= yd_r;
      out_x_relative     <= xr_r;
      out_y_relative     <= yr_r;
      out_autosome_count <= ent_r.cnt_a;
      out_x_count        <= ent_r.cnt_x;
      out_y_count        <= ent_r.cnt_y;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/gc_adjusted_depth_normalizer.sv -----
// ----------------------------------------------------------------------------
// gc_adjusted_depth_normalizer
// Clustered, GC-binned depth statistics with X/Y reweighting on finish.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* channel (valid/ready): one word per record or finish command.
//  - out_* channel (valid/ready): one result word per finish command.
//  - cfg_* channel: register writes, index 0..3, ready is always high.
//  - Record words: the front takes one per cycle while the queue has room
//    and no add is pending; a replacement issues remove then add, and the
//    add holds in_ready low until it is pushed. The back does pop, memory
//    read and write back for each bin op, so it sets the pace of a stream.
//  - Finish: the back walks the autosome bins, then each X and Y bin with a
//    bit-serial divider; its quotient is NQ = 57 + log2(GC_BINS) bits wide.
//  - Reset: the histogram memory is swept to zero with in_ready low;
//    config writes are taken during the sweep.
//  - Out stall: the result waits in the output register; records keep
//    flowing until a second finish reaches the back. It holds there until
//    the slot frees, the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module gc_adjusted_depth_normalizer #(
  parameter int GC_BINS           = 128,
  parameter int CLUSTER_SIZE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gcdn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcdn_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [gcdn_pkg::CHROM_W-1:0]        in_chrom_id,
  input  logic [1:0]                          in_chrom_type,
  input  logic [gcdn_pkg::POS_W-1:0]          in_position,
  input  logic [gcdn_pkg::GC_W-1:0]           in_gc_bin,
  input  logic                                in_gc_unknown,
  input  logic [gcdn_pkg::RAW_W-1:0]          in_raw_depth,
  input  logic [gcdn_pkg::DRAW_W-1:0]         in_random_draw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gcdn_pkg::OUT_DEPTH_W-1:0]    out_autosome_depth,
  output logic [gcdn_pkg::OUT_DEPTH_W-1:0]    out_x_depth,
  output logic [gcdn_pkg::OUT_DEPTH_W-1:0]    out_y_depth,
  output logic [gcdn_pkg::REL_W-1:0]          out_x_relative,
  output logic [gcdn_pkg::REL_W-1:0]          out_y_relative,
  output logic [gcdn_pkg::CNT_W-1:0]          out_autosome_count,
  output logic [gcdn_pkg::CNT_W-1:0]          out_x_count,
  output logic [gcdn_pkg::CNT_W-1:0]          out_y_count
);
  import gcdn_pkg::*;

  cfg_t    cfg_r;
  logic    q_push, q_pop, q_full, q_empty, clear_busy;
  qentry_t q_wdata, q_rdata;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_distance <= MIN_DIST_W'(100);
      cfg_r.depth_cap    <= DEPTH_W'(100);
      cfg_r.x_start      <= POS_W'(2699520);
      cfg_r.x_stop       <= POS_W'(154931044);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_DIST:  cfg_r.min_distance <= cfg_data[MIN_DIST_W-1:0];
        CFG_DEPTH_CAP: cfg_r.depth_cap    <= cfg_data[DEPTH_W-1:0];
        CFG_X_START:   cfg_r.x_start      <= cfg_data[POS_W-1:0];
        CFG_X_STOP:    cfg_r.x_stop       <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // front: chromosome/cluster tracking, emits bin ops
  gcdn_front #(
    .GC_BINS           (GC_BINS),
    .CLUSTER_SIZE_BITS (CLUSTER_SIZE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_chrom_id    (in_chrom_id),
    .in_chrom_type  (in_chrom_type),
    .in_position    (in_position),
    .in_gc_bin      (in_gc_bin),
    .in_gc_unknown  (in_gc_unknown),
    .in_raw_depth   (in_raw_depth),
    .in_random_draw (in_random_draw),
    .clear_busy     (clear_busy),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  // op queue decouples front and back
  gcdn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: histogram RMW and finish math
  gcdn_back #(.GC_BINS(GC_BINS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .clear_busy         (clear_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_autosome_depth (out_autosome_depth),
    .out_x_depth        (out_x_depth),
    .out_y_depth        (out_y_depth),
    .out_x_relative     (out_x_relative),
    .out_y_relative     (out_y_relative),
    .out_autosome_count (out_autosome_count),
    .out_x_count        (out_x_count),
    .out_y_count        (out_y_count)
  );

endmodule

// ----- hw/rtl/gcdn_checker.sv -----
// ----------------------------------------------------------------------------
// gcdn_checker
// Port-level checks for the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module gcdn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [gcdn_pkg::OUT_DEPTH_W-1:0]   out_autosome_depth,
  input logic [gcdn_pkg::OUT_DEPTH_W-1:0]   out_x_depth,
  input logic [gcdn_pkg::REL_W-1:0]         out_x_relative,
  input logic [gcdn_pkg::REL_W-1:0]         out_y_relative
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_depth)
                                && $stable(out_autosome_depth))
    else $error("result changed while stalled");

  // memory sweep keeps input closed right after reset
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clear");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // ratios need a nonzero autosome depth
  a_ratio_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_autosome_depth == '0) |->
      (out_x_relative == '0) && (out_y_relative == '0))
    else $error("ratio without autosome depth");

endmodule

bind gc_adjusted_depth_normalizer gcdn_checker u_chk (.*);
